### rtl/lnp_pkg.sv
// Shared types and constants of the line number program decoder.
// Used by the controller, the datapath and the top level; no dependencies.
package lnp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 64;
  localparam int unsigned RegW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DivW    = 8;
  localparam int unsigned ProdW   = 40;

  localparam int unsigned LebMaxBytesDefault = 10;
  localparam int unsigned SkipLimitDefault   = 4096;

  // Result status codes.
  localparam logic [StatusW-1:0] StatRow       = 2'd0;
  localparam logic [StatusW-1:0] StatBadOpcode = 2'd1;
  localparam logic [StatusW-1:0] StatLebLong   = 2'd2;
  localparam logic [StatusW-1:0] StatTruncated = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgMinInst  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLineBase = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLineRng  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOpBase   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDefStmt  = 3'd4;

  // Opcodes.
  localparam logic [ByteW-1:0] OpExtended   = 8'd0;
  localparam logic [ByteW-1:0] OpCopy       = 8'd1;
  localparam logic [ByteW-1:0] OpAdvPc      = 8'd2;
  localparam logic [ByteW-1:0] OpAdvLine    = 8'd3;
  localparam logic [ByteW-1:0] OpSetFile    = 8'd4;
  localparam logic [ByteW-1:0] OpSetColumn  = 8'd5;
  localparam logic [ByteW-1:0] OpNegStmt    = 8'd6;
  localparam logic [ByteW-1:0] OpBasicBlock = 8'd7;
  localparam logic [ByteW-1:0] OpConstAddPc = 8'd8;
  localparam logic [ByteW-1:0] OpFixedAdvPc = 8'd9;
  localparam logic [ByteW-1:0] ExtEndSeq    = 8'd1;
  localparam logic [ByteW-1:0] ExtSetAddr   = 8'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic div_step;
    logic mul_lo;
    logic mul_hi;
    logic fin;
  } lnp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic defer_div;
    logic defer_mul;
    logic pend_div;
    logic out_full;
  } lnp_stat_t;

endpackage

### rtl/line_number_program_decoder.sv
// Top level of the line number program decoder.
// Instantiates lnp_ctrl and lnp_datapath; uses lnp_pkg.
//
// Usage: program bytes enter on the in channel (program_byte_i, last_byte_i),
// one per transaction; last_byte_i marks the final byte of a unit, after which
// the line state returns to its reset values. Rows and error reports leave on
// the out channel, at most one per input byte. Header values are written on
// the cfg channel (index, 8-bit data); the user must write them only while
// the block is idle, as the block itself does not enforce it. cfg_ready_o is
// always high and an unknown index is ignored. A byte is accepted, then
// executed. A special opcode or the constant address advance then runs the
// 8-bit divider, one quotient bit per cycle, then a multiply and an add; an
// address advance operand, on its last byte, runs its two 32x8 partial products.
// One byte is in work at a time. A waiting result holds off the next byte:
// when the receiver stalls, in_ready_o stays low until the result is taken.
// Reset (rst_ni low, asynchronous) loads the default header values and
// clears the line state and the valid flag of the result register.
module line_number_program_decoder import lnp_pkg::*; #(
  parameter int unsigned LEB_MAX_BYTES = LebMaxBytesDefault,
  parameter int unsigned SKIP_LIMIT    = SkipLimitDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ByteW-1:0]   program_byte_i,
  input  logic               last_byte_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [AddrW-1:0]   row_address_o,
  output logic [RegW-1:0]    row_line_o,
  output logic [RegW-1:0]    row_column_o,
  output logic [RegW-1:0]    row_file_o,
  output logic               row_is_stmt_o,
  output logic               row_seq_end_o
);

  lnp_cmd_t  cmd;
  lnp_stat_t stat;
  logic      accept;

  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  lnp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // Decode and arithmetic.
  lnp_datapath #(
    .LEB_MAX_BYTES (LEB_MAX_BYTES),
    .SKIP_LIMIT    (SKIP_LIMIT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .program_byte_i (program_byte_i),
    .last_byte_i    (last_byte_i),
    .cfg_write_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .row_address_o  (row_address_o),
    .row_line_o     (row_line_o),
    .row_column_o   (row_column_o),
    .row_file_o     (row_file_o),
    .row_is_stmt_o  (row_is_stmt_o),
    .row_seq_end_o  (row_seq_end_o)
  );

`ifndef SYNTHESIS
  // A byte is never taken while a result still waits.
  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input ready while result pending");

  // An accepted byte is in work on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready right after accept");

  // Error reports carry an all-zero row.
  a_error_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StatRow) |-> (row_address_o == '0 && !row_is_stmt_o))
    else $error("error report with row data");
`endif

endmodule

### rtl/lnp_ctrl.sv
// Controller of the line number program decoder: sequences the byte step,
// the divider, the partial products and the final address update. Uses lnp_pkg.
module lnp_ctrl import lnp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  lnp_stat_t stat_i,
  output logic      in_ready_o,
  output lnp_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StExec  = 6'b000010,
    StDiv   = 6'b000100,
    StMulLo = 6'b001000,
    StMulHi = 6'b010000,
    StFin   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [$clog2(DivW)-1:0] div_cnt_q, div_cnt_d;

  // Next state logic.
  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    cmd_o     = '0;
    unique case (state_q)
      StIdle: begin
        if (accept_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        div_cnt_d  = '0;
        if (stat_i.defer_div) begin
          state_d = StDiv;
        end else if (stat_i.defer_mul) begin
          state_d = StMulLo;
        end else begin
          state_d = StIdle;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + 1'b1;
        if (div_cnt_q == ($clog2(DivW))'(DivW - 1)) begin
          state_d = StMulLo;
        end
      end
      StMulLo: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = stat_i.pend_div ? StFin : StMulHi;
      end
      StMulHi: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = StFin;
      end
      StFin: begin
        cmd_o.fin = 1'b1;
        state_d   = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle) && !stat_i.out_full;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

endmodule

### rtl/lnp_datapath.sv
// Datapath of the line number program decoder: configuration, line state
// registers, operand decode, divider, multiplier and result register. Uses lnp_pkg.
module lnp_datapath import lnp_pkg::*; #(
  parameter int unsigned LEB_MAX_BYTES = LebMaxBytesDefault,
  parameter int unsigned SKIP_LIMIT    = SkipLimitDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [ByteW-1:0]   program_byte_i,
  input  logic               last_byte_i,
  input  logic               cfg_write_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  lnp_cmd_t           cmd_i,
  output lnp_stat_t          stat_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [StatusW-1:0] status_o,
  output logic [AddrW-1:0]   row_address_o,
  output logic [RegW-1:0]    row_line_o,
  output logic [RegW-1:0]    row_column_o,
  output logic [RegW-1:0]    row_file_o,
  output logic               row_is_stmt_o,
  output logic               row_seq_end_o
);

  localparam int unsigned CntMax = (SKIP_LIMIT > 10) ? SKIP_LIMIT : 10;
  localparam int unsigned CntW   = $clog2(CntMax + 1);
  localparam int unsigned ShW    = 7;

  typedef enum logic [6:0] {
    PhOp      = 7'b0000001,
    PhExtLen  = 7'b0000010,
    PhExtCode = 7'b0000100,
    PhBytes   = 7'b0001000,
    PhSkip    = 7'b0010000,
    PhUleb    = 7'b0100000,
    PhSleb    = 7'b1000000
  } phase_e;

  // Configuration registers.
  logic [ByteW-1:0] min_inst_q, line_base_q, line_rng_q, op_base_q;
  logic             def_stmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_inst_q  <= 8'd1;
      line_base_q <= 8'hfb;
      line_rng_q  <= 8'd14;
      op_base_q   <= 8'd13;
      def_stmt_q  <= 1'b1;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        CfgMinInst:  min_inst_q  <= cfg_data_i;
        CfgLineBase: line_base_q <= cfg_data_i;
        CfgLineRng:  line_rng_q  <= cfg_data_i;
        CfgOpBase:   op_base_q   <= cfg_data_i;
        CfgDefStmt:  def_stmt_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A zero in a multiplier, range or base register acts as one.
  logic [ByteW-1:0] mi, lr, ob;
  assign mi = (min_inst_q == '0) ? 8'd1 : min_inst_q;
  assign lr = (line_rng_q == '0) ? 8'd1 : line_rng_q;
  assign ob = (op_base_q == '0) ? 8'd1 : op_base_q;

  // State registers.
  logic [AddrW-1:0] addr_q, addr_d;
  logic [RegW-1:0]  line_q, line_d, col_q, col_d, file_q, file_d;
  logic             stmt_q, stmt_d;
  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] cur_op_q, cur_op_d;
  logic [AddrW-1:0] ext_len_q, ext_len_d, acc_q, acc_d;
  logic [ShW-1:0]   shift_q, shift_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             halted_q, halted_d;

  // Accepted byte, pending work and arithmetic registers.
  logic [ByteW-1:0] byte_q;
  logic             last_q;
  logic             pend_div_q, pend_div_d, pend_row_q, pend_row_d;
  logic [DivW-1:0]  quo_q, quo_d;
  logic [DivW:0]    rem_q, rem_d;
  logic [ProdW-1:0] prod_lo_q, prod_lo_d, prod_hi_q, prod_hi_d;

  // Result register.
  logic             out_valid_q, out_valid_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [AddrW-1:0] r_addr_q, r_addr_d;
  logic [RegW-1:0]  r_line_q, r_line_d, r_col_q, r_col_d, r_file_q, r_file_d;
  logic             r_stmt_q, r_stmt_d, r_end_q, r_end_d;

  // Step helpers.
  logic [AddrW-1:0] leb_acc, leb_sext, byte_acc, skip_len;
  logic [ShW-1:0]   leb_sh;
  logic [CntW-1:0]  leb_cnt, byte_cnt;
  logic             leb_end;
  logic [ByteW-1:0] b;
  logic             defer_div, defer_mul, emit, emit_line, emit_end;
  logic [StatusW-1:0] emit_stat;
  logic [DivW:0]    div_try;
  logic [RegW-1:0]  ladv;
  logic [AddrW-1:0] fin_addr;
  logic [RegW-1:0]  fin_line;

  assign b = byte_q;

  // Byte step of a LEB or fixed-width operand, and the clamped skip length.
  always_comb begin
    leb_acc = acc_q;
    if (shift_q < ShW'(64)) begin
      leb_acc = acc_q | (AddrW'(b[6:0]) << shift_q[5:0]);
    end
    leb_cnt  = cnt_q + 1'b1;
    leb_sh   = shift_q + ShW'(7);
    leb_end  = !b[7] || (leb_cnt >= CntW'(LEB_MAX_BYTES));
    leb_sext = leb_acc;
    if ((leb_sh < ShW'(64)) && b[6]) begin
      leb_sext = leb_acc | ({AddrW{1'b1}} << leb_sh[5:0]);
    end
    byte_acc = acc_q;
    if (shift_q < ShW'(64)) begin
      byte_acc = acc_q | (AddrW'(b) << shift_q[5:0]);
    end
    byte_cnt = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
    skip_len = (ext_len_q > AddrW'(1)) ? ext_len_q - AddrW'(1) : '0;
    if (skip_len > AddrW'(SKIP_LIMIT)) begin
      skip_len = AddrW'(SKIP_LIMIT);
    end
  end

  // Divider step, line advance and final address sum.
  assign div_try  = {rem_q[DivW-1:0], quo_q[DivW-1]};
  assign ladv     = {{(RegW-ByteW){line_base_q[ByteW-1]}}, line_base_q}
                    + RegW'(rem_q);
  assign fin_addr = addr_q + AddrW'(prod_lo_q) + {prod_hi_q[RegW-1:0], {RegW{1'b0}}};
  assign fin_line = pend_row_q ? line_q + ladv : line_q;

  // Main step.
  always_comb begin
    addr_d = addr_q;  line_d = line_q;  col_d = col_q;  file_d = file_q;
    stmt_d = stmt_q;  phase_d = phase_q;  cur_op_d = cur_op_q;
    ext_len_d = ext_len_q;  acc_d = acc_q;  shift_d = shift_q;  cnt_d = cnt_q;
    halted_d = halted_q;
    pend_div_d = pend_div_q;  pend_row_d = pend_row_q;
    quo_d = quo_q;  rem_d = rem_q;  prod_lo_d = prod_lo_q;  prod_hi_d = prod_hi_q;
    defer_div = 1'b0;  defer_mul = 1'b0;
    emit = 1'b0;  emit_line = 1'b0;  emit_end = 1'b0;  emit_stat = StatRow;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d = status_q;  r_addr_d = r_addr_q;  r_line_d = r_line_q;
    r_col_d = r_col_q;  r_file_d = r_file_q;  r_stmt_d = r_stmt_q;  r_end_d = r_end_q;

    if (cmd_i.exec) begin
      if (!halted_q) begin
        unique case (phase_q)
          PhOp: begin
            if (b == OpExtended) begin
              phase_d = PhExtLen;  acc_d = '0;  shift_d = '0;  cnt_d = '0;
            end else if (b < ob) begin
              cur_op_d = b;
              case (b)
                OpCopy: begin
                  emit = 1'b1;  emit_line = 1'b1;
                end
                OpAdvPc, OpSetFile, OpSetColumn, OpAdvLine: begin
                  phase_d = (b == OpAdvLine) ? PhSleb : PhUleb;
                  acc_d = '0;  shift_d = '0;  cnt_d = '0;
                end
                OpNegStmt:    stmt_d = ~stmt_q;
                OpBasicBlock: ;
                OpConstAddPc: begin
                  defer_div = 1'b1;  pend_row_d = 1'b0;
                  quo_d = 8'd255 - ob;  rem_d = '0;
                end
                OpFixedAdvPc: begin
                  phase_d = PhBytes;  acc_d = '0;  shift_d = '0;  cnt_d = CntW'(2);
                end
                default: begin
                  emit = 1'b1;  emit_stat = StatBadOpcode;  halted_d = 1'b1;
                end
              endcase
            end else begin
              defer_div = 1'b1;  pend_row_d = 1'b1;
              quo_d = b - ob;  rem_d = '0;
            end
          end
          PhExtLen: begin
            acc_d = leb_acc;  shift_d = leb_sh;  cnt_d = leb_cnt;
            if (leb_end && b[7]) begin
              emit = 1'b1;  emit_stat = StatLebLong;  halted_d = 1'b1;
            end else if (leb_end) begin
              ext_len_d = leb_acc;  phase_d = PhExtCode;
            end
          end
          PhExtCode: begin
            cur_op_d = '0;
            phase_d  = PhOp;
            if (b == ExtEndSeq) begin
              emit = 1'b1;  emit_line = 1'b1;  emit_end = 1'b1;
            end else if (b == ExtSetAddr) begin
              if (ext_len_q >= AddrW'(9)) begin
                phase_d = PhBytes;  acc_d = '0;  shift_d = '0;  cnt_d = CntW'(8);
              end else if (ext_len_q >= AddrW'(5)) begin
                phase_d = PhBytes;  acc_d = '0;  shift_d = '0;  cnt_d = CntW'(4);
              end
            end else if (skip_len != '0) begin
              phase_d = PhSkip;  acc_d = '0;  shift_d = '0;  cnt_d = CntW'(skip_len);
            end
          end
          PhBytes: begin
            acc_d = byte_acc;  shift_d = shift_q + ShW'(8);  cnt_d = byte_cnt;
            if (byte_cnt == '0) begin
              addr_d  = (cur_op_q == OpFixedAdvPc) ? addr_q + byte_acc : byte_acc;
              phase_d = PhOp;
            end
          end
          PhSkip: begin
            cnt_d = byte_cnt;
            if (byte_cnt == '0) begin
              phase_d = PhOp;
            end
          end
          PhUleb: begin
            acc_d = leb_acc;  shift_d = leb_sh;  cnt_d = leb_cnt;
            if (leb_end && b[7]) begin
              emit = 1'b1;  emit_stat = StatLebLong;  halted_d = 1'b1;
            end else if (leb_end) begin
              phase_d = PhOp;
              if (cur_op_q == OpAdvPc) begin
                defer_mul = 1'b1;  pend_div_d = 1'b0;  pend_row_d = 1'b0;
              end else if (cur_op_q == OpSetFile) begin
                file_d = leb_acc[RegW-1:0];
              end else begin
                col_d = leb_acc[RegW-1:0];
              end
            end
          end
          PhSleb: begin
            // Sign extension applies only once the operand is complete.
            acc_d = leb_end ? leb_sext : leb_acc;  shift_d = leb_sh;  cnt_d = leb_cnt;
            if (leb_end) begin
              line_d  = line_q + leb_sext[RegW-1:0];
              phase_d = PhOp;
            end
          end
          default: phase_d = PhOp;
        endcase
      end
      if (defer_div) begin
        pend_div_d = 1'b1;
      end
      // Rows see the register values before an end of sequence clears them.
      if (emit) begin
        out_valid_d = 1'b1;
        status_d    = emit_stat;
        r_addr_d = emit_line ? addr_q : '0;
        r_line_d = emit_line ? line_q : '0;
        r_col_d  = emit_line ? col_q  : '0;
        r_file_d = emit_line ? file_q : '0;
        r_stmt_d = emit_line && stmt_q;
        r_end_d  = emit_end;
      end
      if (emit_end) begin
        addr_d = '0;  line_d = 32'd1;  col_d = '0;  file_d = 32'd1;  stmt_d = def_stmt_q;
      end
      // The last byte of the unit closes any open instruction and resets state.
      if (last_q && !defer_div && !defer_mul) begin
        if (!halted_q && !emit && (phase_d != PhOp)) begin
          out_valid_d = 1'b1;
          status_d = StatTruncated;
          r_addr_d = '0;  r_line_d = '0;  r_col_d = '0;  r_file_d = '0;
          r_stmt_d = 1'b0;  r_end_d = 1'b0;
        end
        addr_d = '0;  line_d = 32'd1;  col_d = '0;  file_d = 32'd1;  stmt_d = def_stmt_q;
        phase_d = PhOp;  cur_op_d = '0;  ext_len_d = '0;  acc_d = '0;  shift_d = '0;
        cnt_d = '0;  halted_d = 1'b0;
      end
    end

    // One quotient bit per cycle, restoring.
    if (cmd_i.div_step) begin
      if (div_try >= {1'b0, lr}) begin
        rem_d = div_try - {1'b0, lr};
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = div_try;
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
    end

    // Address advance products, low word first.
    if (cmd_i.mul_lo) begin
      prod_lo_d = pend_div_q ? ProdW'(quo_q) * ProdW'(mi)
                             : ProdW'(acc_q[RegW-1:0]) * ProdW'(mi);
      prod_hi_d = '0;
    end
    if (cmd_i.mul_hi) begin
      prod_hi_d = ProdW'(acc_q[AddrW-1:RegW]) * ProdW'(mi);
    end

    // Apply the deferred address and line advance.
    if (cmd_i.fin) begin
      addr_d = fin_addr;
      line_d = fin_line;
      if (pend_row_q) begin
        out_valid_d = 1'b1;
        status_d = StatRow;
        r_addr_d = fin_addr;  r_line_d = fin_line;  r_col_d = col_q;  r_file_d = file_q;
        r_stmt_d = stmt_q;  r_end_d = 1'b0;
      end
      if (last_q) begin
        addr_d = '0;  line_d = 32'd1;  col_d = '0;  file_d = 32'd1;  stmt_d = def_stmt_q;
        phase_d = PhOp;  cur_op_d = '0;  ext_len_d = '0;  acc_d = '0;  shift_d = '0;
        cnt_d = '0;  halted_d = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;  line_q <= 32'd1;  col_q <= '0;  file_q <= 32'd1;  stmt_q <= 1'b1;
      phase_q <= PhOp;  cur_op_q <= '0;  ext_len_q <= '0;  acc_q <= '0;
      shift_q <= '0;  cnt_q <= '0;  halted_q <= 1'b0;
      pend_div_q <= 1'b0;  pend_row_q <= 1'b0;  out_valid_q <= 1'b0;
    end else begin
      addr_q <= addr_d;  line_q <= line_d;  col_q <= col_d;  file_q <= file_d;
      stmt_q <= stmt_d;  phase_q <= phase_d;  cur_op_q <= cur_op_d;
      ext_len_q <= ext_len_d;  acc_q <= acc_d;  shift_q <= shift_d;  cnt_q <= cnt_d;
      halted_q <= halted_d;  pend_div_q <= pend_div_d;  pend_row_q <= pend_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      byte_q <= program_byte_i;
      last_q <= last_byte_i;
    end
    quo_q <= quo_d;  rem_q <= rem_d;  prod_lo_q <= prod_lo_d;  prod_hi_q <= prod_hi_d;
    status_q <= status_d;  r_addr_q <= r_addr_d;  r_line_q <= r_line_d;
    r_col_q <= r_col_d;  r_file_q <= r_file_d;  r_stmt_q <= r_stmt_d;  r_end_q <= r_end_d;
  end

  assign stat_o.defer_div = defer_div;
  assign stat_o.defer_mul = defer_mul;
  assign stat_o.pend_div  = pend_div_q;
  assign stat_o.out_full  = out_valid_q;

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign row_address_o = r_addr_q;
  assign row_line_o    = r_line_q;
  assign row_column_o  = r_col_q;
  assign row_file_o    = r_file_q;
  assign row_is_stmt_o = r_stmt_q;
  assign row_seq_end_o = r_end_q;

endmodule
